### rtl/apnc_pkg.sv
// Package for the archive path name checker.
// Holds the verdict codes, character constants, register indexes and item structs.
// No dependencies.
package apnc_pkg;

  // Verdict codes, ranked by the entry tracker
  typedef enum logic [3:0] {
    V_OK          = 4'd0,
    V_EMPTY       = 4'd1,
    V_ABSOLUTE    = 4'd2,
    V_VOLUME      = 4'd3,
    V_PARENT      = 4'd4,
    V_BACKSLASH   = 4'd5,
    V_NUL         = 4'd6,
    V_CONTROL     = 4'd7,
    V_EMPTYCOMP   = 4'd8,
    V_DOT         = 4'd9,
    V_TRAILING    = 4'd10,
    V_COMPTOOLONG = 4'd11,
    V_PATHTOOLONG = 4'd12
  } verdict_t;

  // Characters of interest
  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_DOT    = 8'h2E;
  localparam logic [7:0] CHR_SLASH  = 8'h2F;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_DEL    = 8'h7F;

  // Register widths, reset values and indexes
  localparam int unsigned MAX_PATH_W = 16;
  localparam int unsigned MAX_COMP_W = 10;
  localparam logic [MAX_PATH_W-1:0] MAX_PATH_RESET = 16'd4096;
  localparam logic [MAX_COMP_W-1:0] MAX_COMP_RESET = 10'd255;
  localparam logic REG_MAX_PATH = 1'b0;
  localparam logic REG_MAX_COMP = 1'b1;

  // One input item
  typedef struct packed {
    logic [7:0] name_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  // One result item
  typedef struct packed {
    verdict_t verdict;
    logic     ends_in_slash;
  } result_t;

endpackage

### rtl/apnc_entry.sv
// Entry tracker for the archive path name checker: per-name state and verdict logic.
// Depends on apnc_pkg.
module apnc_entry
  import apnc_pkg::*;
#(
  parameter int unsigned PATH_COUNT_BITS      = 17,
  parameter int unsigned COMPONENT_COUNT_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  item_t                 item,
  input  logic [MAX_PATH_W-1:0] max_path_length,
  input  logic [MAX_COMP_W-1:0] max_component_length,
  output result_t               result
);

  localparam int unsigned PATH_CMP_W =
    (PATH_COUNT_BITS > MAX_PATH_W) ? PATH_COUNT_BITS : MAX_PATH_W;
  localparam int unsigned COMP_CMP_W =
    (COMPONENT_COUNT_BITS > MAX_COMP_W) ? COMPONENT_COUNT_BITS : MAX_COMP_W;

  logic [PATH_COUNT_BITS-1:0]      byte_count_r, byte_count_nxt;
  logic [COMPONENT_COUNT_BITS-1:0] comp_len_r, comp_len_nxt;
  logic                            all_dots_r, all_dots_nxt;
  logic [7:0]                      prev_byte_r, prev_byte_nxt;
  logic                            lead_slash_r, lead_slash_nxt;
  verdict_t                        byte_err_r, byte_err_nxt;
  verdict_t                        comp_err_r, comp_err_nxt;

  logic [7:0] b;
  logic       has;
  logic       is_slash;
  logic       slash_end;
  verdict_t   final_check;
  verdict_t   verdict;

  // Rank the checks on a completed component
  function automatic verdict_t check_comp(
    input logic [COMPONENT_COUNT_BITS-1:0] len,
    input logic                            dots,
    input logic [7:0]                      lastb,
    input logic [MAX_COMP_W-1:0]           limit
  );
    verdict_t v;
    if (len == '0) begin
      v = V_EMPTYCOMP;
    end else if (dots && len == COMPONENT_COUNT_BITS'(1)) begin
      v = V_DOT;
    end else if (dots && len == COMPONENT_COUNT_BITS'(2)) begin
      v = V_PARENT;
    end else if (COMP_CMP_W'(len) > COMP_CMP_W'(limit)) begin
      v = V_COMPTOOLONG;
    end else if (lastb == CHR_DOT || lastb == CHR_SPACE) begin
      v = V_TRAILING;
    end else begin
      v = V_OK;
    end
    return v;
  endfunction

  assign b        = item.name_byte;
  assign has      = item.has_byte;
  assign is_slash = (b == CHR_SLASH);

  // Fold the byte into the entry state
  always_comb begin
    byte_count_nxt = byte_count_r;
    comp_len_nxt   = comp_len_r;
    all_dots_nxt   = all_dots_r;
    prev_byte_nxt  = prev_byte_r;
    lead_slash_nxt = lead_slash_r;
    byte_err_nxt   = byte_err_r;
    comp_err_nxt   = comp_err_r;
    if (has) begin
      if (byte_err_r == V_OK) begin
        if (b == CHR_NUL) begin
          byte_err_nxt = V_NUL;
        end else if (b == CHR_BSLASH) begin
          byte_err_nxt = V_BACKSLASH;
        end else if (b == CHR_COLON) begin
          byte_err_nxt = V_VOLUME;
        end else if (b < CHR_SPACE || b == CHR_DEL) begin
          byte_err_nxt = V_CONTROL;
        end
      end
      if (byte_count_r == '0 && is_slash) begin
        lead_slash_nxt = 1'b1;
      end
      if (is_slash) begin
        if (comp_err_r == V_OK) begin
          comp_err_nxt = check_comp(comp_len_r, all_dots_r, prev_byte_r,
                                    max_component_length);
        end
        comp_len_nxt = '0;
        all_dots_nxt = 1'b1;
      end else begin
        if (!(&comp_len_r)) begin
          comp_len_nxt = comp_len_r + COMPONENT_COUNT_BITS'(1);
        end
        if (b != CHR_DOT) begin
          all_dots_nxt = 1'b0;
        end
      end
      prev_byte_nxt = b;
      if (!(&byte_count_r)) begin
        byte_count_nxt = byte_count_r + PATH_COUNT_BITS'(1);
      end
    end
  end

  // Rank the verdict on the state after this byte
  assign slash_end   = (byte_count_nxt != '0) && (prev_byte_nxt == CHR_SLASH);
  assign final_check = check_comp(comp_len_nxt, all_dots_nxt, prev_byte_nxt,
                                  max_component_length);

  always_comb begin
    if (byte_count_nxt == '0) begin
      verdict = V_EMPTY;
    end else if (byte_err_nxt != V_OK) begin
      verdict = byte_err_nxt;
    end else if (lead_slash_nxt) begin
      verdict = V_ABSOLUTE;
    end else if (PATH_CMP_W'(byte_count_nxt) > PATH_CMP_W'(max_path_length)) begin
      verdict = V_PATHTOOLONG;
    end else if (comp_err_nxt != V_OK || slash_end) begin
      verdict = comp_err_nxt;
    end else begin
      verdict = final_check;
    end
  end

  assign result.verdict       = verdict;
  assign result.ends_in_slash = slash_end;

  // Advance the state; clear it once the name is finished
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      byte_count_r <= '0;
      comp_len_r   <= '0;
      all_dots_r   <= 1'b1;
      prev_byte_r  <= CHR_NUL;
      lead_slash_r <= 1'b0;
      byte_err_r   <= V_OK;
      comp_err_r   <= V_OK;
    end else if (step) begin
      byte_count_r <= byte_count_nxt;
      comp_len_r   <= comp_len_nxt;
      all_dots_r   <= all_dots_nxt;
      prev_byte_r  <= prev_byte_nxt;
      lead_slash_r <= lead_slash_nxt;
      byte_err_r   <= byte_err_nxt;
      comp_err_r   <= comp_err_nxt;
    end
  end

endmodule

### rtl/archive_path_name_checker_core.sv
// Archive path name checker, top level: input register, entry tracker, result register.
// Depends on apnc_pkg and apnc_entry.
//
// The block takes one byte of an archive entry name per item and, on the item
// marked last, gives one verdict and an ends-in-slash flag. It accepts one item
// every clock cycle while in_ready is high. An item is held in the input
// register and passes through the entry tracker; for an item marked last the
// result is captured in the result register. While a result waits for
// out_ready, an item marked last holds in the input register and in_ready
// drops. The user must write the two length limits over the APB-style port at
// byte addresses 0 (path) and 4 (component) only while no name is in flight;
// the block itself does not enforce this.
module archive_path_name_checker_core
  import apnc_pkg::*;
#(
  parameter int unsigned PATH_COUNT_BITS      = 17,
  parameter int unsigned COMPONENT_COUNT_BITS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_verdict,
  output logic        out_ends_in_slash,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  s1_valid_r;
  item_t                 s1_item_r;
  logic                  out_valid_r;
  result_t               out_res_r;
  logic [MAX_PATH_W-1:0] max_path_r;
  logic [MAX_COMP_W-1:0] max_comp_r;

  logic    out_free;
  logic    s1_step;
  logic    cfg_wr;
  result_t entry_res;

  // Hold an item with a result until the result register frees up
  assign out_free = !out_valid_r || out_ready;
  assign s1_step  = s1_valid_r && (!s1_item_r.last || out_free);
  assign in_ready = !s1_valid_r || s1_step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.name_byte <= in_name_byte;
      s1_item_r.has_byte  <= in_has_byte;
      s1_item_r.last      <= in_last;
    end
  end

  apnc_entry #(
    .PATH_COUNT_BITS      (PATH_COUNT_BITS),
    .COMPONENT_COUNT_BITS (COMPONENT_COUNT_BITS)
  ) u_entry (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (s1_step),
    .item                 (s1_item_r),
    .max_path_length      (max_path_r),
    .max_component_length (max_comp_r),
    .result               (entry_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_step && s1_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_item_r.last) begin
      out_res_r <= entry_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_res_r.verdict;
  assign out_ends_in_slash = out_res_r.ends_in_slash;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_path_r <= MAX_PATH_RESET;
      max_comp_r <= MAX_COMP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_PATH: max_path_r <= pwdata[MAX_PATH_W-1:0];
        REG_MAX_COMP: max_comp_r <= pwdata[MAX_COMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_MAX_PATH: prdata = 32'(max_path_r);
      REG_MAX_COMP: prdata = 32'(max_comp_r);
      default:      prdata = '0;
    endcase
  end

endmodule

### bench/archive_path_name_checker_core_tb.sv
// Self-checking bench for archive_path_name_checker_core.
// Feeds entry names byte by byte, predicts each verdict in-bench and checks every result.
// Depends on apnc_pkg and the core RTL.
module archive_path_name_checker_core_tb;
  import apnc_pkg::*;

  localparam int unsigned PATH_BITS = 17;
  localparam int unsigned COMP_BITS = 11;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [2:0] ADDR_PATH = {REG_MAX_PATH, 2'b00};
  localparam logic [2:0] ADDR_COMP = {REG_MAX_COMP, 2'b00};
  localparam logic [PATH_BITS-1:0] PATH_SAT = '1;
  localparam logic [COMP_BITS-1:0] COMP_SAT = '1;

  typedef logic [7:0] name_t[$];

  // Ways a random name is spoilt
  typedef enum int {
    F_RAW_BYTE, F_BAD_CHAR, F_LEADING_SLASH, F_DOT_COMP, F_PARENT_COMP,
    F_EXTRA_SLASH, F_TRAILING_CHAR, F_JUMBLE, F_EMPTY, F_LONG_COMP
  } fault_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_name_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_verdict;
  logic        out_ends_in_slash;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  archive_path_name_checker_core #(
    .PATH_COUNT_BITS      (PATH_BITS),
    .COMPONENT_COUNT_BITS (COMP_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_name_byte      (in_name_byte),
    .in_has_byte       (in_has_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .out_ends_in_slash (out_ends_in_slash),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Limit registers as the bench believes them
  logic [15:0] limit_path;
  logic [9:0]  limit_comp;

  // Per-name tracking state of the verdict predictor
  logic [PATH_BITS-1:0] name_len;
  logic [COMP_BITS-1:0] comp_len;
  logic                 comp_all_dots;
  logic [7:0]           prev_char;
  logic                 leading_slash;
  verdict_t             char_fault;
  verdict_t             comp_fault;

  result_t pending_verdicts[$];
  result_t oldest;
  bit      steady;
  int      mismatches;
  int      verdicts_seen;
  int      items_sent;
  int      settings_used;
  int      quiet_cycles;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  // Append one byte to the end of a name
  function automatic void add_char(ref name_t q, input logic [7:0] c);
    q.insert(q.size(), c);
  endfunction

  // Queue an expected verdict behind the ones already waiting
  function automatic void queue_verdict(input result_t res);
    pending_verdicts.insert(pending_verdicts.size(), res);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void clear_name();
    name_len      = '0;
    comp_len      = '0;
    comp_all_dots = 1'b1;
    prev_char     = CHR_NUL;
    leading_slash = 1'b0;
    char_fault    = V_OK;
    comp_fault    = V_OK;
  endfunction

  // Judge the component just closed; prev_char is its last byte
  function automatic verdict_t judge_component();
    if (comp_len == 0) return V_EMPTYCOMP;
    if (comp_all_dots && comp_len == 1) return V_DOT;
    if (comp_all_dots && comp_len == 2) return V_PARENT;
    if (comp_len > limit_comp) return V_COMPTOOLONG;
    if (prev_char == CHR_DOT || prev_char == CHR_SPACE) return V_TRAILING;
    return V_OK;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    if (char_fault == V_OK) begin
      if (c == CHR_NUL) char_fault = V_NUL;
      else if (c == CHR_BSLASH) char_fault = V_BACKSLASH;
      else if (c == CHR_COLON) char_fault = V_VOLUME;
      else if (c < CHR_SPACE || c == CHR_DEL) char_fault = V_CONTROL;
    end
    if (name_len == 0 && c == CHR_SLASH) leading_slash = 1'b1;
    if (c == CHR_SLASH) begin
      if (comp_fault == V_OK) comp_fault = judge_component();
      comp_len      = '0;
      comp_all_dots = 1'b1;
    end else begin
      if (comp_len != COMP_SAT) comp_len = comp_len + 1'b1;
      if (c != CHR_DOT) comp_all_dots = 1'b0;
    end
    prev_char = c;
    if (name_len != PATH_SAT) name_len = name_len + 1'b1;
  endfunction

  // Advance the predictor by one item; return 1 when a verdict is due
  function automatic bit predict_verdict(input logic [7:0] c, input logic has,
                                         input logic fin, output result_t res);
    logic slash_end;
    res = '0;
    if (has) absorb_char(c);
    if (!fin) return 1'b0;
    slash_end = (name_len != 0) && (prev_char == CHR_SLASH);
    if (name_len == 0) res.verdict = V_EMPTY;
    else if (char_fault != V_OK) res.verdict = char_fault;
    else if (leading_slash) res.verdict = V_ABSOLUTE;
    else if (name_len > limit_path) res.verdict = V_PATHTOOLONG;
    else begin
      res.verdict = comp_fault;
      if (res.verdict == V_OK && !slash_end) res.verdict = judge_component();
    end
    res.ends_in_slash = slash_end;
    clear_name();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Compare each accepted result with the oldest expected verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result verdict %0d slash %0b",
                         out_verdict, out_ends_in_slash));
      end else begin
        oldest = pending_verdicts.pop_front();
        verdicts_seen++;
        if (out_verdict !== oldest.verdict)
          report($sformatf("verdict expected %0d got %0d", oldest.verdict, out_verdict));
        if (out_ends_in_slash !== oldest.ends_in_slash)
          report($sformatf("ends_in_slash expected %0b got %0b",
                           oldest.ends_in_slash, out_ends_in_slash));
      end
    end
  end

  // Stall the result channel at random unless a steady stretch is running
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 20);
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Send one item and predict its verdict once it is taken
  task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
    result_t res;
    while (!steady && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_name_byte = c;
    in_has_byte  = has;
    in_last      = fin;
    do @(posedge clk); while (!in_ready);
    if (predict_verdict(c, has, fin, res)) queue_verdict(res);
    @(negedge clk);
  endtask

  // Send a whole name; a detached end closes it with a byteless last item
  task automatic send_name(input name_t chars, input bit detached_end, input bit noisy);
    for (int i = 0; i < chars.size(); i++) begin
      if (noisy && $urandom_range(99) < 5) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(chars[i], 1'b1, !detached_end && (i == chars.size() - 1));
      items_sent++;
    end
    if (detached_end || chars.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  function automatic name_t text(input string s);
    name_t q;
    for (int i = 0; i < s.len(); i++) add_char(q, s[i]);
    return q;
  endfunction

  // Hold the input idle until every verdict is back and the core has settled
  task automatic settle();
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_limits();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_PATH, '0, rd);
    if (rd !== {16'd0, limit_path})
      report($sformatf("max_path_length read expected %0d got %0d", limit_path, rd));
    apb_xfer(1'b0, ADDR_COMP, '0, rd);
    if (rd !== {22'd0, limit_comp})
      report($sformatf("max_component_length read expected %0d got %0d", limit_comp, rd));
  endtask

  task automatic set_limits(input logic [31:0] path_word, input logic [31:0] comp_word);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, ADDR_PATH, path_word, rd);
    limit_path = path_word[15:0];
    apb_xfer(1'b1, ADDR_COMP, comp_word, rd);
    limit_comp = comp_word[9:0];
    check_limits();
    settings_used++;
  endtask

  // ---------------------------------------------------------------- random names

  function automatic logic [7:0] clean_char();
    string alnum;
    logic [7:0] c;
    alnum = "abcdefghijklmnopqrstuvwxyz0123456789";
    if ($urandom_range(99) < 60) return alnum[$urandom_range(0, alnum.len() - 1)];
    c = 8'($urandom_range(8'h21, 8'hFF));
    if (c == CHR_SLASH || c == CHR_DOT || c == CHR_COLON || c == CHR_BSLASH || c == CHR_DEL)
      c = "a";
    return c;
  endfunction

  // Build a well-formed name, then spoil it in some cases
  function automatic name_t random_name();
    name_t q;
    string jumble_set;
    fault_t fault;
    int ncomp;
    int len;
    jumble_set = "./ a";
    ncomp = $urandom_range(1, 4);
    for (int c = 0; c < ncomp; c++) begin
      if (c > 0) add_char(q, CHR_SLASH);
      len = ($urandom_range(99) < 10) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      repeat (len) add_char(q, clean_char());
    end
    if ($urandom_range(99) < 15) add_char(q, CHR_SLASH);
    if ($urandom_range(99) < 55) return q;
    fault = fault_t'($urandom_range(F_RAW_BYTE, F_LONG_COMP));
    case (fault)
      F_RAW_BYTE: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      F_BAD_CHAR: begin
        case ($urandom_range(0, 4))
          0: q.insert($urandom_range(0, q.size()), CHR_NUL);
          1: q.insert($urandom_range(0, q.size()), CHR_BSLASH);
          2: q.insert($urandom_range(0, q.size()), CHR_COLON);
          3: q.insert($urandom_range(0, q.size()), CHR_DEL);
          default: q.insert($urandom_range(0, q.size()), 8'($urandom_range(1, 31)));
        endcase
      end
      F_LEADING_SLASH: q.push_front(CHR_SLASH);
      F_DOT_COMP: begin
        q.push_front(CHR_SLASH);
        q.push_front(CHR_DOT);
      end
      F_PARENT_COMP: begin
        q.push_front(CHR_SLASH);
        q.push_front(CHR_DOT);
        q.push_front(CHR_DOT);
      end
      F_EXTRA_SLASH: q.insert($urandom_range(0, q.size()), CHR_SLASH);
      F_TRAILING_CHAR: begin
        add_char(q, $urandom_range(0, 1) ? CHR_DOT : CHR_SPACE);
        if ($urandom_range(0, 1)) add_char(q, CHR_SLASH);
      end
      F_JUMBLE: begin
        q.delete();
        repeat ($urandom_range(1, 6)) add_char(q, jumble_set[$urandom_range(0, 3)]);
      end
      F_EMPTY: q.delete();
      default: repeat ($urandom_range(4, 12)) add_char(q, "x");
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    check_limits();
    send_name(text("docs/readme.txt"), 1'b0, 1'b0);
  endtask

  // Bad bytes, first one wins, ranked above every other error
  task automatic test_byte_errors();
    name_t q;
    send_name(text("a:b"), 1'b0, 1'b0);
    send_name(text("a\\b"), 1'b0, 1'b0);
    q = text("ab");
    q.insert(1, CHR_NUL);
    send_name(q, 1'b0, 1'b0);
    q = {8'h1F};
    send_name(q, 1'b0, 1'b0);
    q = {CHR_DEL};
    send_name(q, 1'b0, 1'b0);
    send_name(text("\\:"), 1'b0, 1'b0);
    q = {CHR_SLASH, 8'h01};
    send_name(q, 1'b0, 1'b0);
    // high bytes are fine; a byteless item mid-name is ignored
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    items_sent += 3;
  endtask

  task automatic test_name_structure();
    send_name(text(""), 1'b0, 1'b0);
    send_name(text("/"), 1'b0, 1'b0);
    send_name(text("/a"), 1'b0, 1'b0);
    send_name(text("a/"), 1'b0, 1'b0);
    send_name(text("a//"), 1'b0, 1'b0);
    send_name(text("a//b"), 1'b0, 1'b0);
    send_name(text("."), 1'b0, 1'b0);
    send_name(text(".."), 1'b0, 1'b0);
    send_name(text("./a"), 1'b0, 1'b0);
    send_name(text("a/../b"), 1'b0, 1'b0);
    send_name(text("..."), 1'b0, 1'b0);
    send_name(text("a."), 1'b0, 1'b0);
    send_name(text("a /b"), 1'b0, 1'b0);
    send_name(text("ab/"), 1'b1, 1'b0);
  endtask

  // Both limits at their extremes and at zero
  task automatic test_limits();
    set_limits(32'd1, 32'd1);
    send_name(text("ab"), 1'b0, 1'b0);
    send_name(text("a"), 1'b0, 1'b0);
    set_limits(32'd0, 32'd0);
    send_name(text("a"), 1'b0, 1'b0);
    set_limits(32'd65535, 32'd0);
    send_name(text("a"), 1'b0, 1'b0);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_name(text("abc/d"), 1'b0, 1'b0);
  endtask

  // Names just past and exactly at both length limits
  task automatic test_long_names();
    name_t q;
    set_limits(32'd40, 32'd10);
    for (int i = 0; i < 45; i++) add_char(q, (i % 10 == 9) ? CHR_SLASH : 8'h61);
    send_name(q, 1'b0, 1'b0);
    q.delete();
    repeat (12) add_char(q, "a");
    add_char(q, CHR_SLASH);
    add_char(q, "b");
    send_name(q, 1'b0, 1'b0);
    q.delete();
    for (int i = 0; i < 40; i++) add_char(q, (i % 11 == 10) ? CHR_SLASH : 8'h61);
    send_name(q, 1'b0, 1'b0);
  endtask

  task automatic test_random_names();
    int start;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limits(32'(MAX_PATH_RESET), 32'(MAX_COMP_RESET));
        1: set_limits(32'd12, 32'd3);
        2: set_limits(32'd30, 32'd6);
        3: set_limits(32'd6, 32'd1);
        4: set_limits(32'd65535, 32'd1023);
        default: set_limits($urandom_range(1, 48), $urandom_range(1, 10));
      endcase
      // keep both channels flowing for one whole phase
      steady = (phase == 2);
      start = items_sent;
      while (items_sent - start < 200)
        send_name(random_name(), $urandom_range(9) == 0, 1'b1);
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_name_byte = '0;
    in_has_byte  = 1'b0;
    in_last      = 1'b0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    limit_path   = MAX_PATH_RESET;
    limit_comp   = MAX_COMP_RESET;
    clear_name();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_register_reset();
    test_byte_errors();
    test_name_structure();
    test_limits();
    test_long_names();
    test_random_names();

    // Drain and let the pipeline empty
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d verdicts checked from %0d items under %0d limit settings,",
             verdicts_seen, items_sent, settings_used);
    $display("with names at the length limits, byteless items and stalls on both sides.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
